// ===== sv/mccs_pkg.sv =====
// Package: microcode word, condition flags and constants for the coin change solver.
`default_nettype none
package mccs_pkg;

   localparam int COIN_W  = 12;
   localparam int CNT_W   = 6;
   localparam int COST_W  = 7;
   localparam int UPC_W   = 4;
   localparam int OP_W    = 4;
   localparam int COND_W  = 3;

   localparam logic [COST_W-1:0] COST_INF = 7'd127;

   // datapath operations
   localparam logic [OP_W-1:0] OP_IDLE       = 4'd0;
   localparam logic [OP_W-1:0] OP_ROW_INIT   = 4'd1;
   localparam logic [OP_W-1:0] OP_ROW_LATCH  = 4'd2;
   localparam logic [OP_W-1:0] OP_CELL_RD    = 4'd3;
   localparam logic [OP_W-1:0] OP_CELL_WR    = 4'd4;
   localparam logic [OP_W-1:0] OP_ROW_END    = 4'd5;
   localparam logic [OP_W-1:0] OP_BEST_RD    = 4'd6;
   localparam logic [OP_W-1:0] OP_BEST_LATCH = 4'd7;
   localparam logic [OP_W-1:0] OP_BEST_CHK   = 4'd8;
   localparam logic [OP_W-1:0] OP_TR_RD      = 4'd9;
   localparam logic [OP_W-1:0] OP_TR_STEP    = 4'd10;
   localparam logic [OP_W-1:0] OP_NOP        = 4'd11;

   // jump conditions
   localparam logic [COND_W-1:0] C_NEXT     = 3'd0;
   localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] C_NO_SOLVE = 3'd2;
   localparam logic [COND_W-1:0] C_AMT_ZERO = 3'd3;
   localparam logic [COND_W-1:0] C_J_MORE   = 3'd4;
   localparam logic [COND_W-1:0] C_I_MORE   = 3'd5;
   localparam logic [COND_W-1:0] C_TRIVIAL  = 3'd6;
   localparam logic [COND_W-1:0] C_TR_MORE  = 3'd7;

   // program steps
   localparam logic [UPC_W-1:0] UPC_IDLE       = 4'd0;
   localparam logic [UPC_W-1:0] UPC_ROW_INIT   = 4'd1;
   localparam logic [UPC_W-1:0] UPC_ROW_LATCH  = 4'd2;
   localparam logic [UPC_W-1:0] UPC_CELL_RD    = 4'd3;
   localparam logic [UPC_W-1:0] UPC_CELL_WR    = 4'd4;
   localparam logic [UPC_W-1:0] UPC_ROW_END    = 4'd5;
   localparam logic [UPC_W-1:0] UPC_BEST_RD    = 4'd6;
   localparam logic [UPC_W-1:0] UPC_BEST_LATCH = 4'd7;
   localparam logic [UPC_W-1:0] UPC_BEST_CHK   = 4'd8;
   localparam logic [UPC_W-1:0] UPC_TR_RD      = 4'd9;
   localparam logic [UPC_W-1:0] UPC_TR_STEP    = 4'd10;
   localparam logic [UPC_W-1:0] UPC_TR_LOOP    = 4'd11;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [UPC_W-1:0]  target;
   } ucode_word_type;

   typedef struct packed {
      logic no_solve;
      logic amt_zero;
      logic j_more;
      logic i_more;
      logic trivial;
      logic tr_more;
   } flags_type;

   function automatic ucode_word_type ucode_rom(input logic [UPC_W-1:0] pc);
      ucode_word_type w;
      unique case (pc)
         UPC_IDLE:       w = '{op: OP_IDLE,       cond: C_NO_SOLVE, target: UPC_IDLE};
         UPC_ROW_INIT:   w = '{op: OP_ROW_INIT,   cond: C_NEXT,     target: UPC_IDLE};
         UPC_ROW_LATCH:  w = '{op: OP_ROW_LATCH,  cond: C_AMT_ZERO, target: UPC_ROW_END};
         UPC_CELL_RD:    w = '{op: OP_CELL_RD,    cond: C_NEXT,     target: UPC_IDLE};
         UPC_CELL_WR:    w = '{op: OP_CELL_WR,    cond: C_J_MORE,   target: UPC_CELL_RD};
         UPC_ROW_END:    w = '{op: OP_ROW_END,    cond: C_I_MORE,   target: UPC_ROW_INIT};
         UPC_BEST_RD:    w = '{op: OP_BEST_RD,    cond: C_NEXT,     target: UPC_IDLE};
         UPC_BEST_LATCH: w = '{op: OP_BEST_LATCH, cond: C_NEXT,     target: UPC_IDLE};
         UPC_BEST_CHK:   w = '{op: OP_BEST_CHK,   cond: C_TRIVIAL,  target: UPC_IDLE};
         UPC_TR_RD:      w = '{op: OP_TR_RD,      cond: C_NEXT,     target: UPC_IDLE};
         UPC_TR_STEP:    w = '{op: OP_TR_STEP,    cond: C_TR_MORE,  target: UPC_TR_RD};
         UPC_TR_LOOP:    w = '{op: OP_NOP,        cond: C_ALWAYS,   target: UPC_IDLE};
         default:        w = '{op: OP_NOP,        cond: C_ALWAYS,   target: UPC_IDLE};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== sv/mccs_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none
module mccs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== sv/mccs_useq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none
module mccs_useq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mccs_pkg::flags_type     flags,
   output mccs_pkg::ucode_word_type     ctrl
);

   logic [mccs_pkg::UPC_W-1:0] pc_ff;
   logic [mccs_pkg::UPC_W-1:0] pc_in;
   logic                       take;

   assign ctrl = mccs_pkg::ucode_rom(pc_ff);

   always_comb begin
      unique case (ctrl.cond)
         mccs_pkg::C_NEXT:     take = 1'b0;
         mccs_pkg::C_ALWAYS:   take = 1'b1;
         mccs_pkg::C_NO_SOLVE: take = flags.no_solve;
         mccs_pkg::C_AMT_ZERO: take = flags.amt_zero;
         mccs_pkg::C_J_MORE:   take = flags.j_more;
         mccs_pkg::C_I_MORE:   take = flags.i_more;
         mccs_pkg::C_TRIVIAL:  take = flags.trivial;
         mccs_pkg::C_TR_MORE:  take = flags.tr_more;
         default:              take = 1'b1;
      endcase
      pc_in = take ? ctrl.target : mccs_pkg::UPC_W'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= mccs_pkg::UPC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/mccs_datapath.sv =====
// Datapath: denomination store, cost table, index registers and result registers.
`default_nettype none
module mccs_datapath #(
   parameter int MAX_DENOMS = 16,
   parameter int MAX_AMOUNT = 63
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire mccs_pkg::ucode_word_type        ctrl,
   output mccs_pkg::flags_type                  flags,
   input  wire logic                            start,
   input  wire logic [mccs_pkg::COIN_W-1:0]     req_denomination,
   input  wire logic                            req_last_denomination,
   input  wire logic [mccs_pkg::CNT_W-1:0]      req_amount,
   output logic                                 rsp_strobe,
   output logic      [mccs_pkg::COIN_W-1:0]     rsp_coin,
   output logic      [mccs_pkg::CNT_W-1:0]      rsp_min_coins,
   output logic                                 rsp_reachable,
   output logic                                 rsp_last_result
);

   localparam int IW = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
   localparam int JW = $clog2(MAX_AMOUNT + 1);
   localparam int CW = $clog2(MAX_DENOMS + 1);
   localparam int AW = IW + JW;
   localparam int COST_DEPTH = MAX_DENOMS << JW;
   localparam int CW_ = mccs_pkg::COIN_W;

   localparam logic [CW-1:0] DENOM_MAX = CW'(MAX_DENOMS);
   localparam logic [mccs_pkg::CNT_W-1:0] AMT_MAX = mccs_pkg::CNT_W'(MAX_AMOUNT);

   logic [CW-1:0]                  count_ff;
   logic [IW-1:0]                  n_ff;
   logic [JW-1:0]                  amt_ff;
   logic [IW-1:0]                  i_ff;
   logic [JW-1:0]                  j_ff;
   logic [CW_-1:0]                 d_ff;
   logic [mccs_pkg::COST_W-1:0]    best_ff;
   logic                           strobe_ff;
   logic [CW_-1:0]                 coin_ff;
   logic [mccs_pkg::CNT_W-1:0]     min_ff;
   logic                           reach_ff;
   logic                           last_ff;

   logic [CW-1:0]                  count_in;
   logic [IW-1:0]                  n_in;
   logic [JW-1:0]                  amt_in;
   logic [IW-1:0]                  i_in;
   logic [JW-1:0]                  j_in;
   logic [CW_-1:0]                 d_in;
   logic [mccs_pkg::COST_W-1:0]    best_in;
   logic                           strobe_in;
   logic [CW_-1:0]                 coin_in;
   logic [mccs_pkg::CNT_W-1:0]     min_in;
   logic                           reach_in;
   logic                           last_in;

   logic                           accept;
   logic                           store_en;
   logic [CW-1:0]                  count_inc;
   logic [mccs_pkg::CNT_W-1:0]     amt_clamp;
   logic [IW-1:0]                  i_dec;
   logic                           i_nz;
   logic [CW_-1:0]                 j_ext;
   logic [CW_-1:0]                 denom_rd;
   logic [mccs_pkg::COST_W-1:0]    cost_a;
   logic [mccs_pkg::COST_W-1:0]    cost_b;
   logic                           cost_we;
   logic [AW-1:0]                  cost_waddr;
   logic [mccs_pkg::COST_W-1:0]    cost_wdata;
   logic [AW-1:0]                  raddr_a;
   logic [AW-1:0]                  raddr_b;
   logic [mccs_pkg::COST_W-1:0]    excl;
   logic [mccs_pkg::COST_W-1:0]    inc;
   logic [mccs_pkg::COST_W-1:0]    cell_val;
   logic                           tr_eq;
   logic                           tr_done;

   assign accept    = start && (ctrl.op == mccs_pkg::OP_IDLE);
   assign store_en  = accept && (count_ff < DENOM_MAX);
   assign count_inc = store_en ? CW'(count_ff + 1'b1) : count_ff;
   assign amt_clamp = (req_amount > AMT_MAX) ? AMT_MAX : req_amount;
   assign i_dec     = IW'(i_ff - 1'b1);
   assign i_nz      = (i_ff != '0);
   assign j_ext     = {{(CW_ - JW){1'b0}}, j_ff};

   mccs_ram #(.WIDTH(CW_), .DEPTH(MAX_DENOMS), .AW(IW)) u_denom_ram (
      .clock (clock),
      .we    (store_en),
      .waddr (count_ff[IW-1:0]),
      .wdata (req_denomination),
      .raddr (i_ff),
      .rdata (denom_rd)
   );

   mccs_ram #(.WIDTH(mccs_pkg::COST_W), .DEPTH(COST_DEPTH), .AW(AW)) u_cost_ram_a (
      .clock (clock),
      .we    (cost_we),
      .waddr (cost_waddr),
      .wdata (cost_wdata),
      .raddr (raddr_a),
      .rdata (cost_a)
   );

   mccs_ram #(.WIDTH(mccs_pkg::COST_W), .DEPTH(COST_DEPTH), .AW(AW)) u_cost_ram_b (
      .clock (clock),
      .we    (cost_we),
      .waddr (cost_waddr),
      .wdata (cost_wdata),
      .raddr (raddr_b),
      .rdata (cost_b)
   );

   always_comb begin
      excl = i_nz ? cost_a : mccs_pkg::COST_INF;
      inc  = (cost_b >= mccs_pkg::COST_INF - 1'b1) ? mccs_pkg::COST_INF
                                                   : mccs_pkg::COST_W'(cost_b + 1'b1);
      cell_val = excl;
      if ((d_ff != '0) && (j_ext >= d_ff)) begin
         cell_val = (excl < inc) ? excl : inc;
      end
   end

   always_comb begin
      unique case (ctrl.op)
         mccs_pkg::OP_CELL_RD: begin
            raddr_a = {i_dec, j_ff};
            raddr_b = {i_ff, JW'(j_ff - d_ff[JW-1:0])};
         end
         mccs_pkg::OP_BEST_RD: begin
            raddr_a = {i_ff, amt_ff};
            raddr_b = {i_dec, j_ff};
         end
         default: begin
            raddr_a = {i_ff, j_ff};
            raddr_b = {i_dec, j_ff};
         end
      endcase
   end

   always_comb begin
      cost_we    = 1'b0;
      cost_waddr = {i_ff, j_ff};
      cost_wdata = cell_val;
      if (ctrl.op == mccs_pkg::OP_ROW_INIT) begin
         cost_we    = 1'b1;
         cost_waddr = {i_ff, {JW{1'b0}}};
         cost_wdata = '0;
      end else if (ctrl.op == mccs_pkg::OP_CELL_WR) begin
         cost_we = 1'b1;
      end
   end

   assign tr_eq   = i_nz && (cost_a == cost_b);
   assign tr_done = !tr_eq && (j_ext == denom_rd);

   always_comb begin
      flags.no_solve = !(accept && req_last_denomination);
      flags.amt_zero = (amt_ff == '0);
      flags.j_more   = (j_ff != amt_ff);
      flags.i_more   = (i_ff != n_ff);
      flags.trivial  = (best_ff >= mccs_pkg::COST_INF) || (amt_ff == '0);
      flags.tr_more  = !tr_done;
   end

   always_comb begin
      count_in  = count_ff;
      n_in      = n_ff;
      amt_in    = amt_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      d_in      = d_ff;
      best_in   = best_ff;
      strobe_in = 1'b0;
      coin_in   = coin_ff;
      min_in    = min_ff;
      reach_in  = reach_ff;
      last_in   = last_ff;
      unique case (ctrl.op)
         mccs_pkg::OP_IDLE: begin
            if (accept) begin
               count_in = count_inc;
               if (req_last_denomination) begin
                  count_in = '0;
                  n_in     = IW'(count_inc - 1'b1);
                  amt_in   = amt_clamp[JW-1:0];
                  i_in     = '0;
               end
            end
         end
         mccs_pkg::OP_ROW_INIT: begin
            j_in = JW'(1);
         end
         mccs_pkg::OP_ROW_LATCH: begin
            d_in = denom_rd;
         end
         mccs_pkg::OP_CELL_WR: begin
            j_in = JW'(j_ff + 1'b1);
         end
         mccs_pkg::OP_ROW_END: begin
            if (i_ff != n_ff) begin
               i_in = IW'(i_ff + 1'b1);
            end
         end
         mccs_pkg::OP_BEST_RD: begin
            j_in = amt_ff;
         end
         mccs_pkg::OP_BEST_LATCH: begin
            best_in = cost_a;
         end
         mccs_pkg::OP_BEST_CHK: begin
            if (flags.trivial) begin
               strobe_in = 1'b1;
               coin_in   = '0;
               min_in    = '0;
               reach_in  = (best_ff < mccs_pkg::COST_INF);
               last_in   = 1'b1;
            end
         end
         mccs_pkg::OP_TR_STEP: begin
            if (tr_eq) begin
               i_in = i_dec;
            end else begin
               strobe_in = 1'b1;
               coin_in   = denom_rd;
               min_in    = best_ff[mccs_pkg::CNT_W-1:0];
               reach_in  = 1'b1;
               last_in   = tr_done;
               j_in      = JW'(j_ff - denom_rd[JW-1:0]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      n_ff    <= n_in;
      amt_ff  <= amt_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      d_ff    <= d_in;
      best_ff <= best_in;
      coin_ff <= coin_in;
      min_ff  <= min_in;
      reach_ff <= reach_in;
      last_ff <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_coin        = coin_ff;
   assign rsp_min_coins   = min_ff;
   assign rsp_reachable   = reach_ff;
   assign rsp_last_result = last_ff;

endmodule
`default_nettype wire

// ===== sv/min_coin_change_solver_top.sv =====
// Top level of the minimum coin change solver: microcode sequencer and datapath.
// A denomination request without the last mark leaves the solver idle; the next may follow at once.
// A solving request keeps the solver busy for table fill (per row: init, denomination latch,
// a read and a write step per cell on the cost table RAM port, row end), best-cost read, latch
// and check, then a read and a step per traceback step (row step or coin) and a closing step.
// Results leave as one-cycle strobes that cannot be stalled; synchronous reset empties the
// denomination store and returns the sequencer to idle.
`default_nettype none
module min_coin_change_solver_top #(
   parameter int MAX_DENOMS = 16,
   parameter int MAX_AMOUNT = 63
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [mccs_pkg::COIN_W-1:0] req_denomination,
   input  wire logic                        req_last_denomination,
   input  wire logic [mccs_pkg::CNT_W-1:0]  req_amount,
   output logic                             rsp_strobe,
   output logic      [mccs_pkg::COIN_W-1:0] rsp_coin,
   output logic      [mccs_pkg::CNT_W-1:0]  rsp_min_coins,
   output logic                             rsp_reachable,
   output logic                             rsp_last_result
);

   mccs_pkg::ucode_word_type ctrl;
   mccs_pkg::flags_type      flags;

   mccs_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   mccs_datapath #(.MAX_DENOMS(MAX_DENOMS), .MAX_AMOUNT(MAX_AMOUNT)) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .ctrl                  (ctrl),
      .flags                 (flags),
      .start                 (start),
      .req_denomination      (req_denomination),
      .req_last_denomination (req_last_denomination),
      .req_amount            (req_amount),
      .rsp_strobe            (rsp_strobe),
      .rsp_coin              (rsp_coin),
      .rsp_min_coins         (rsp_min_coins),
      .rsp_reachable         (rsp_reachable),
      .rsp_last_result       (rsp_last_result)
   );

   assign busy = (ctrl.op != mccs_pkg::OP_IDLE);

endmodule
`default_nettype wire
